// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros for the run length scanner
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// assertion on an explicit clock and active-low reset
`define BRS_ASSERT_AT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// assertion on the default clock and reset names
`define BRS_ASSERT(lbl, prop, msg) \
  `BRS_ASSERT_AT(lbl, clk_i, rst_ni, prop, msg)

`endif

// ===== hdl/brs_pkg.sv =====
// ----------------------------------------------------------------------------
// brs_pkg
// shared constants, types and helpers of the bitmap run length scanner
// ----------------------------------------------------------------------------
package brs_pkg;

  localparam int MAX_PIECES = 4096;
  localparam int MODE_W     = 2;
  localparam int IDX_W      = 12;
  localparam int CNT_W      = 13;
  localparam int WORD_W     = 64;
  localparam int OFF_W      = $clog2(WORD_W);
  localparam int POS_W      = OFF_W + 1;
  localparam int WORDS      = (MAX_PIECES + WORD_W - 1) / WORD_W;
  localparam int WADDR_W    = $clog2(WORDS);

  typedef enum logic [MODE_W-1:0] {
    MODE_SET     = 2'd0,
    MODE_CLR     = 2'd1,
    MODE_RUN_SET = 2'd2,
    MODE_RUN_CLR = 2'd3
  } mode_e;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_FETCH = 5'b00010,
    ST_MARK  = 5'b00100,
    ST_SCAN  = 5'b01000,
    ST_DONE  = 5'b10000
  } state_e;

  typedef struct packed {
    logic take;
    logic fetch;
    logic mark_wr;
    logic scan;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic in_range;
    logic is_mark;
    logic scan_more;
  } sts_t;

  // number of consecutive ones from bit 0, WORD_W when all ones
  function automatic logic [POS_W-1:0] trail_ones(input logic [WORD_W-1:0] v);
    logic [WORD_W-1:0] z;
    logic [WORD_W-1:0] m;
    logic [POS_W-1:0]  n;
    z = ~v;
    n = '0;
    if (&v) begin
      n = POS_W'(WORD_W);
    end else begin
      for (int s = OFF_W - 1; s >= 0; s--) begin
        m = (WORD_W'(1) << (1 << s)) - WORD_W'(1);
        if ((z & m) == '0) begin
          n = n + POS_W'(1 << s);
          z = z >> (1 << s);
        end
      end
    end
    return n;
  endfunction

endpackage

// ===== hdl/brs_ifs.sv =====
// ----------------------------------------------------------------------------
// brs_ifs
// valid/ready channels for request and result beats
// ----------------------------------------------------------------------------
interface brs_in_if;
  logic                         valid;
  logic                         ready;
  logic [brs_pkg::MODE_W-1:0]   mode;
  logic [brs_pkg::IDX_W-1:0]    piece_index;

  modport source (output valid, output mode, output piece_index, input ready);
  modport sink   (input valid, input mode, input piece_index, output ready);
endinterface

interface brs_out_if;
  logic                         valid;
  logic                         ready;
  logic [brs_pkg::CNT_W-1:0]    run_length;
  logic                         index_in_range;

  modport source (output valid, output run_length, output index_in_range, input ready);
  modport sink   (input valid, input run_length, input index_in_range, output ready);
endinterface

// ===== hdl/brs_ram.sv =====
// ----------------------------------------------------------------------------
// brs_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module brs_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/brs_ctrl.sv =====
// ----------------------------------------------------------------------------
// brs_ctrl
// sequencer for mark and run scan requests, owns the result beat valid
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module brs_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output brs_pkg::cmd_t cmd_o,
  input  brs_pkg::sts_t sts_i
);

  brs_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      brs_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = sts_i.in_range ? brs_pkg::ST_FETCH : brs_pkg::ST_DONE;
        end
      end
      brs_pkg::ST_FETCH: begin
        cmd_o.fetch = 1'b1;
        state_d     = sts_i.is_mark ? brs_pkg::ST_MARK : brs_pkg::ST_SCAN;
      end
      brs_pkg::ST_MARK: begin
        cmd_o.mark_wr = 1'b1;
        state_d       = brs_pkg::ST_DONE;
      end
      brs_pkg::ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (!sts_i.scan_more) begin
          state_d = brs_pkg::ST_DONE;
        end
      end
      brs_pkg::ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = brs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = brs_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= brs_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `BRS_ASSERT(a_mark_only_for_marks, cmd_o.mark_wr |-> sts_i.is_mark, "write on a query")
  `BRS_ASSERT(a_result_from_done, $rose(out_valid_q) |-> $past(state_q == brs_pkg::ST_DONE), "result beat without finish")
  `BRS_ASSERT(a_scan_after_fetch, (state_q == brs_pkg::ST_SCAN) |-> ($past(state_q == brs_pkg::ST_FETCH) || $past(state_q == brs_pkg::ST_SCAN)), "scan without fetch")

endmodule

// ===== hdl/brs_dpath.sv =====
// ----------------------------------------------------------------------------
// brs_dpath
// count register, word valid bits, mark update and word-wise run counter
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module brs_dpath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [brs_pkg::CNT_W-1:0]     cfg_wdata_i,
  input  logic [brs_pkg::MODE_W-1:0]    mode_i,
  input  logic [brs_pkg::IDX_W-1:0]     piece_index_i,
  input  brs_pkg::cmd_t                 cmd_i,
  output brs_pkg::sts_t                 sts_o,
  output logic                          ram_we_o,
  output logic [brs_pkg::WADDR_W-1:0]   ram_waddr_o,
  output logic [brs_pkg::WORD_W-1:0]    ram_wdata_o,
  output logic [brs_pkg::WADDR_W-1:0]   ram_raddr_o,
  input  logic [brs_pkg::WORD_W-1:0]    ram_rdata_i,
  output logic [brs_pkg::CNT_W-1:0]     run_length_o,
  output logic                          index_in_range_o
);

  logic [brs_pkg::CNT_W-1:0]   cnt_q;
  logic [brs_pkg::CNT_W-1:0]   eff_cnt;
  brs_pkg::mode_e              mode_q;
  logic [brs_pkg::WADDR_W-1:0] word_q;
  logic [brs_pkg::OFF_W-1:0]   off_q;
  logic [brs_pkg::CNT_W-1:0]   run_q;
  logic                        ok_q;
  logic [brs_pkg::WORDS-1:0]   word_valid_q;
  logic                        rd_vld_q;
  logic [brs_pkg::CNT_W-1:0]   out_run_q;
  logic                        out_ok_q;

  logic [brs_pkg::WORD_W-1:0]  word_data;
  logic [brs_pkg::WORD_W-1:0]  bit_mask;
  logic [brs_pkg::WORD_W-1:0]  match;
  logic [brs_pkg::WORD_W-1:0]  hit;
  logic [brs_pkg::CNT_W-1:0]   base;
  logic [brs_pkg::CNT_W-1:0]   next_base;
  logic [brs_pkg::CNT_W-1:0]   lim;
  logic [brs_pkg::POS_W-1:0]   ones;
  logic [brs_pkg::CNT_W-1:0]   gain;

  // counts above capacity saturate
  assign eff_cnt = (cnt_q > brs_pkg::CNT_W'(brs_pkg::MAX_PIECES))
                   ? brs_pkg::CNT_W'(brs_pkg::MAX_PIECES) : cnt_q;

  assign sts_o.in_range  = brs_pkg::CNT_W'(piece_index_i) < eff_cnt;
  assign sts_o.is_mark   = (mode_q == brs_pkg::MODE_SET) || (mode_q == brs_pkg::MODE_CLR);

  // never-written words read as all absent
  assign word_data = rd_vld_q ? ram_rdata_i : '0;
  assign bit_mask  = brs_pkg::WORD_W'(1) << off_q;

  assign ram_we_o    = cmd_i.mark_wr;
  assign ram_waddr_o = word_q;
  assign ram_wdata_o = (mode_q == brs_pkg::MODE_SET) ? (word_data | bit_mask)
                                                     : (word_data & ~bit_mask);
  assign ram_raddr_o = cmd_i.fetch ? word_q : word_q + brs_pkg::WADDR_W'(1);

  assign match     = (mode_q == brs_pkg::MODE_RUN_SET) ? word_data : ~word_data;
  assign base      = brs_pkg::CNT_W'({word_q, {brs_pkg::OFF_W{1'b0}}});
  assign next_base = base + brs_pkg::CNT_W'(brs_pkg::WORD_W);
  assign lim       = eff_cnt - base;

  // bits below the start count as matching, bits past the count as not
  always_comb begin
    for (int p = 0; p < brs_pkg::WORD_W; p++) begin
      hit[p] = (match[p] && (brs_pkg::CNT_W'(p) < lim)) || (brs_pkg::OFF_W'(p) < off_q);
    end
  end

  assign ones            = brs_pkg::trail_ones(hit);
  assign gain            = brs_pkg::CNT_W'(ones) - brs_pkg::CNT_W'(off_q);
  assign sts_o.scan_more = (ones == brs_pkg::POS_W'(brs_pkg::WORD_W)) && (next_base < eff_cnt);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q        <= brs_pkg::CNT_W'(brs_pkg::MAX_PIECES);
      word_valid_q <= '0;
    end else begin
      if (cfg_we_i) begin
        cnt_q <= cfg_wdata_i;
      end
      if (cmd_i.mark_wr) begin
        word_valid_q[word_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_vld_q <= word_valid_q[ram_raddr_o];
    if (cmd_i.take) begin
      mode_q <= brs_pkg::mode_e'(mode_i);
      word_q <= piece_index_i[brs_pkg::IDX_W-1:brs_pkg::OFF_W];
      off_q  <= piece_index_i[brs_pkg::OFF_W-1:0];
      run_q  <= '0;
      ok_q   <= sts_o.in_range;
    end else if (cmd_i.scan) begin
      run_q <= run_q + gain;
      if (sts_o.scan_more) begin
        word_q <= word_q + brs_pkg::WADDR_W'(1);
        off_q  <= '0;
      end
    end
    if (cmd_i.out_load) begin
      out_run_q <= run_q;
      out_ok_q  <= ok_q;
    end
  end

  assign run_length_o     = out_run_q;
  assign index_in_range_o = out_ok_q;

  `BRS_ASSERT(a_written_word_valid, cmd_i.mark_wr |=> word_valid_q[$past(word_q)], "written word not marked valid")

endmodule

// ===== hdl/bitmap_run_length_scanner.sv =====
// ----------------------------------------------------------------------------
// bitmap_run_length_scanner
// presence bitmap with mark / unmark and run length queries from a start piece
// ----------------------------------------------------------------------------
//  channel  dir  handshake        payload
//  cfg      in   cfg_we_i         cfg_wdata_i (piece_count)
//  in_i     in   valid / ready    mode, piece_index
//  out_o    out  valid / ready    run_length, index_in_range
//
//  one request in flight; out of range requests go from accept to the finish step,
//  marks fetch and write one word, queries walk w 64-bit words (1 to 64)
//  the walk reads one bitmap word a cycle from the single ram read port
//  reset clears the bitmap at once through per-word valid bits, no sweep
//  a pending result beat does not block the next request; a stalled result
//  holds the request in its finish step until the beat leaves
// ----------------------------------------------------------------------------
module bitmap_run_length_scanner (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [brs_pkg::CNT_W-1:0] cfg_wdata_i,
  brs_in_if.sink                    in_i,
  brs_out_if.source                 out_o
);

  brs_pkg::cmd_t               cmd;
  brs_pkg::sts_t               sts;
  logic                        ram_we;
  logic [brs_pkg::WADDR_W-1:0] ram_waddr;
  logic [brs_pkg::WORD_W-1:0]  ram_wdata;
  logic [brs_pkg::WADDR_W-1:0] ram_raddr;
  logic [brs_pkg::WORD_W-1:0]  ram_rdata;

  // sequencer: request accept, fetch, mark write, word walk, result beat
  brs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // datapath: count register, range check, bit update, run counter
  brs_dpath u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .mode_i           (in_i.mode),
    .piece_index_i    (in_i.piece_index),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .ram_we_o         (ram_we),
    .ram_waddr_o      (ram_waddr),
    .ram_wdata_o      (ram_wdata),
    .ram_raddr_o      (ram_raddr),
    .ram_rdata_i      (ram_rdata),
    .run_length_o     (out_o.run_length),
    .index_in_range_o (out_o.index_in_range)
  );

  // bitmap store, 64 pieces per word, piece i at bit i mod 64
  brs_ram #(
    .WIDTH (brs_pkg::WORD_W),
    .DEPTH (brs_pkg::WORDS)
  ) u_bitmap (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule
